// ===== src/spd_pkg.sv =====
// Shared types, constants and codes of the stream prefetch detector.
package spd_pkg;

  localparam int unsigned DETECTORS_DEF = 64;
  localparam int unsigned GROUP         = 8;
  localparam int unsigned GROUP_W       = 3;

  localparam int unsigned LINE_ADDR_W = 58;
  localparam int unsigned OCC_W       = 6;
  localparam int unsigned PAGE_W      = 52;
  localparam int unsigned OFF_W       = 6;
  localparam int unsigned ADDR_W      = 64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned WINDOW_W  = 7;
  localparam int unsigned DEGREE_W  = 3;
  localparam int unsigned THR_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY   = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 7'd16;
  localparam logic [DEGREE_W-1:0] DEGREE_RST = 3'd2;
  localparam logic [THR_W-1:0]    BUSY_RST   = 6'd8;
  localparam logic [DEGREE_W-1:0] MAX_DEGREE = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  localparam logic [1:0] CONF_MAX = 2'd3;
  localparam logic [1:0] CONF_MIN_ISSUE = 2'd2;

  localparam logic signed [7:0] IDX_HI   = 8'sd64;
  localparam logic signed [7:0] IDX_LO   = -8'sd1;
  localparam logic signed [7:0] LINE_MAX = 8'sd63;
  localparam logic signed [7:0] LINE_MIN = 8'sd0;

  typedef struct packed {
    logic [LINE_ADDR_W-1:0] line_address;
    logic [OCC_W-1:0]       miss_occupancy;
  } spd_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefetch_address;
    logic              llc_fill;
    logic              last_of_run;
  } spd_out_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [1:0] conf;
    logic [7:0] idx;
  } meta_t;

  localparam int unsigned META_W = $bits(meta_t);

  typedef struct packed {
    logic capture;
    logic match;
    logic lookup;
    logic train;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } status_t;

endpackage

// ===== src/stream_prefetch_detector_core.sv =====
// Top level of the stream prefetch detector: controller and datapath.
// The first beat is registered out of the run state, after match, lookup and train.
// An access keeps busy_o high through these states and a run that issues n prefetches
// (0 to 4), one line step per cycle, and a new access is taken only once busy_o is low.
// Beats are strobed for one cycle, never stalled.
// Reset restores the register defaults, clears all tags and detector state at once.
module stream_prefetch_detector_core #(
  parameter int unsigned DETECTORS = spd_pkg::DETECTORS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  spd_pkg::spd_in_t              in_i,
  output logic                          result_valid_o,
  output spd_pkg::spd_out_t             result_o
);
  import spd_pkg::*;

  cmd_t    cmd;
  status_t status;

  spd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  spd_datapath #(
    .DETECTORS (DETECTORS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== src/spd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module spd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spd_ctrl.sv =====
// Controller state machine sequencing search, training and the prefetch run.
module spd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  spd_pkg::status_t  status_i,
  output spd_pkg::cmd_t     cmd_o,
  output logic              busy_o
);
  import spd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_TRAIN  = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_TRAIN;
      end
      ST_TRAIN: begin
        cmd_o.train = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (status_i.stop) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== src/spd_datapath.sv =====
// Datapath: configuration, page tag search, detector state RAM, training and prefetch run.
module spd_datapath #(
  parameter int unsigned DETECTORS = spd_pkg::DETECTORS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  spd_pkg::spd_in_t                  in_i,
  input  spd_pkg::cmd_t                     cmd_i,
  output spd_pkg::status_t                  status_o,
  output logic                              result_valid_o,
  output spd_pkg::spd_out_t                 result_o
);
  import spd_pkg::*;

  localparam int unsigned IDX_W = $clog2(DETECTORS);
  localparam int unsigned NGRP  = (DETECTORS + GROUP - 1) / GROUP;
  localparam int unsigned GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned SEL_W = GRP_W + GROUP_W;
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(DETECTORS - 1);

  logic [WINDOW_W-1:0]    window_q;
  logic [DEGREE_W-1:0]    degree_q;
  logic [THR_W-1:0]       busy_thr_q;
  logic [LINE_ADDR_W-1:0] line_q;
  logic                   fill_q;

  logic [PAGE_W-1:0]      tag_q [DETECTORS];
  logic [DETECTORS-1:0]   valid_q;
  logic [IDX_W-1:0]       oldest_q;

  logic [NGRP-1:0]        grp_hit_q, grp_hit;
  logic [GROUP_W-1:0]     grp_loc_q [NGRP];
  logic [GROUP_W-1:0]     grp_loc [NGRP];
  logic                   hit_q;
  logic [IDX_W-1:0]       d_q;

  meta_t                  cur_q;
  logic [DEGREE_W-1:0]    limit_q, cnt_q;

  logic                   result_valid_q;
  spd_out_t               result_q;

  logic [PAGE_W-1:0]      page;
  logic [OFF_W-1:0]       off;
  logic [DETECTORS-1:0]   match;
  logic [NGRP*GROUP-1:0]  match_pad;

  assign page = line_q[LINE_ADDR_W-1:OFF_W];
  assign off  = line_q[OFF_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_RST;
      degree_q   <= DEGREE_RST;
      busy_thr_q <= BUSY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW: window_q   <= cfg_wdata_i[WINDOW_W-1:0];
        CFG_DEGREE: degree_q   <= cfg_wdata_i[DEGREE_W-1:0];
        CFG_BUSY:   busy_thr_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      line_q <= in_i.line_address;
      fill_q <= (in_i.miss_occupancy > busy_thr_q);
    end
  end

  // Tag comparison against every detector, reduced per group of eight.
  for (genvar e = 0; e < DETECTORS; e++) begin : g_cmp
    assign match[e] = (tag_q[e] == page);
  end

  always_comb begin
    match_pad                  = '0;
    match_pad[DETECTORS-1:0]   = match;
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] = 1'b0;
      grp_loc[g] = '0;
      for (int k = GROUP - 1; k >= 0; k--) begin
        if (match_pad[g*GROUP + k]) begin
          grp_hit[g] = 1'b1;
          grp_loc[g] = GROUP_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_hit_q <= '0;
    end else if (cmd_i.match) begin
      grp_hit_q <= grp_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      grp_loc_q <= grp_loc;
    end
  end

  // Lowest matching group, then the victim entry on a miss.
  logic               hit;
  logic [GRP_W-1:0]   gsel;
  logic [SEL_W-1:0]   sel;
  logic [IDX_W-1:0]   victim;

  always_comb begin
    hit  = 1'b0;
    gsel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit  = 1'b1;
        gsel = GRP_W'(g);
      end
    end
    sel    = {gsel, grp_loc_q[gsel]};
    victim = hit ? sel[IDX_W-1:0] : oldest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      hit_q    <= 1'b0;
      d_q      <= '0;
      for (int e = 0; e < DETECTORS; e++) begin
        tag_q[e] <= '0;
      end
    end else if (cmd_i.lookup) begin
      hit_q <= hit;
      d_q   <= victim;
      if (!hit) begin
        tag_q[oldest_q] <= page;
        oldest_q        <= (oldest_q == LAST_ENTRY) ? '0 : oldest_q + 1'b1;
      end
    end
  end

  // Detector state RAM.
  logic   ram_we;
  meta_t  ram_wdata;
  logic [META_W-1:0] ram_rdata;

  spd_ram #(
    .WIDTH (META_W),
    .DEPTH (DETECTORS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (d_q),
    .wdata_i (ram_wdata),
    .raddr_i (victim),
    .rdata_o (ram_rdata)
  );

  // Training.
  meta_t                 meta_rd, meta_tr;
  logic signed [7:0]     rd_idx, diff;
  logic [7:0]            span;
  logic [1:0]            opposite;
  logic [DEGREE_W-1:0]   deg_clip;

  always_comb begin
    if (!hit_q) begin
      meta_rd = '{dir: DIR_NONE, conf: 2'd0, idx: {2'b00, off}};
    end else if (valid_q[d_q]) begin
      meta_rd = meta_t'(ram_rdata);
    end else begin
      meta_rd = '{dir: DIR_NONE, conf: 2'd0, idx: IDX_LO};
    end
    rd_idx   = $signed(meta_rd.idx);
    diff     = $signed({2'b00, off}) - rd_idx;
    span     = diff[7] ? 8'(-diff) : 8'(diff);
    opposite = diff[7] ? DIR_UP : DIR_DOWN;
    meta_tr  = meta_rd;
    if ((diff != 8'sd0) && (span < {1'b0, window_q})) begin
      if (meta_rd.dir == opposite) begin
        meta_tr.conf = 2'd0;
      end else if (meta_rd.conf != CONF_MAX) begin
        meta_tr.conf = meta_rd.conf + 2'd1;
      end
      meta_tr.dir = diff[7] ? DIR_DOWN : DIR_UP;
    end
    deg_clip = (degree_q > MAX_DEGREE) ? MAX_DEGREE : degree_q;
  end

  // Prefetch run: one line step per cycle.
  logic signed [7:0]   cur_idx, nidx;
  logic                oob, count_done, stop, emit, last;
  logic [DEGREE_W-1:0] cnt_inc;

  always_comb begin
    cur_idx = $signed(cur_q.idx);
    case (cur_q.dir)
      DIR_UP:   nidx = (cur_idx >= IDX_HI) ? IDX_HI : cur_idx + 8'sd1;
      DIR_DOWN: nidx = (cur_idx <= IDX_LO) ? IDX_LO : cur_idx - 8'sd1;
      default:  nidx = cur_idx;
    endcase
    oob        = (nidx < LINE_MIN) || (nidx > LINE_MAX);
    count_done = (cnt_q == limit_q);
    stop       = count_done || oob;
    emit       = cmd_i.run && !stop;
    cnt_inc    = cnt_q + 1'b1;
    last       = (cnt_inc == limit_q) ||
                 ((cur_q.dir == DIR_UP) && (nidx == LINE_MAX)) ||
                 ((cur_q.dir == DIR_DOWN) && (nidx == LINE_MIN));
    ram_we     = cmd_i.run && stop;
    ram_wdata  = '{dir: cur_q.dir, conf: cur_q.conf,
                   idx: count_done ? cur_q.idx : nidx};
  end

  assign status_o.stop = stop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.train) begin
      cur_q   <= meta_tr;
      cnt_q   <= '0;
      limit_q <= (meta_tr.conf >= CONF_MIN_ISSUE) ? deg_clip : '0;
    end else if (emit) begin
      cur_q.idx <= nidx;
      cnt_q     <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[d_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q.prefetch_address <= {page, nidx[OFF_W-1:0], {OFF_W{1'b0}}};
      result_q.llc_fill         <= fill_q;
      result_q.last_of_run      <= last;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== src/spd_checker.sv =====
// Port level checker of the stream prefetch detector and its bind to the top level.
module spd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [spd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [spd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input logic                          start_i,
  input logic                          busy_o,
  input spd_pkg::spd_in_t              in_i,
  input logic                          result_valid_o,
  input spd_pkg::spd_out_t             result_o
);

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_index_i) ^ (^cfg_wdata_i) ^ (^in_i);

  a_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("Prefetch beat seen while the block is idle.");

  a_no_early_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o && !result_valid_o ##1 !result_valid_o
                             ##1 !result_valid_o)
    else $error("Prefetch beat too soon after an access was taken.");

  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_of_run) |=> result_valid_o)
    else $error("Prefetch run ended without a last beat.");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_of_run) |=> !result_valid_o)
    else $error("Prefetch beat after the last beat of a run.");

  a_line_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.prefetch_address[5:0] == 6'd0))
    else $error("Prefetch address is not line aligned.");

endmodule

bind stream_prefetch_detector_core spd_checker u_spd_checker (.*);
